// ===== hdl/rcao_pkg.sv =====
package rcao_pkg;

    // field widths
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int SECS_W      = 8;
    localparam int TPS_W       = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    // parsed value saturates just above the largest clamp, which keeps order and zero-ness
    localparam int             VALUE_W   = 9;
    localparam logic [VALUE_W-1:0] VALUE_CAP = 9'd256;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TICK     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_ON_SECONDS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ON_SECONDS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW         = 2'd3;

    // configuration reset values
    localparam logic [SECS_W-1:0] DEFAULT_ON_SECONDS_RST = 8'd5;
    localparam logic [SECS_W-1:0] MAX_ON_SECONDS_RST     = 8'd30;
    localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_RST   = 20'd1000;
    localparam logic              ACTIVE_LOW_RST         = 1'b1;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    typedef enum logic [3:0] {
        P_START,
        P_O,
        P_ON,
        P_OF,
        P_OFF,
        P_COLON,
        P_SIGN,
        P_DIGITS,
        P_FAIL
    } parse_state_t;

    typedef struct packed {
        logic               accepted;
        logic               cmd_off;
        logic               cmd_on_default;
        logic [VALUE_W-1:0] value;
    } verdict_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                relay_on;
        logic                pin_level;
        logic                state_changed;
    } result_t;

endpackage

// ===== hdl/relay_command_with_auto_off_top.sv =====
// Relay command block with auto-off timer. Each input transfer is either one command
// character (tuser 0, tdata the byte, tlast on the final character) or one timer tick
// (tuser 1). Commands OFF, ON and ON:n are trimmed of whitespace and matched without case,
// and are recognised on the fly as characters arrive, so no command buffer is kept.
// One result comes out per tick and per final character; other characters give none.
// The block takes one item every cycle: an input register and a result register hold
// the item and its result; the result register loads from the input register when the
// staged item moves on and has a result. Input is held back only while the result
// register is full and not taken and the staged item has a result of its own.
// No clearing pass after reset. Configuration is written through cfg_wr_en / cfg_index /
// cfg_data; the user must write it only while idle, which the block itself does not enforce.
module relay_command_with_auto_off_top #(
    parameter int CMD_BUFFER_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rcao_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] char_byte
    input  logic [0:0]                         s_axis_tuser,  // [0] action
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] cmd_status, [2] relay_on, [3] pin_level, [4] state_changed, [7:5] zero
    output logic [rcao_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [rcao_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rcao_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rcao_pkg::*;

    logic [SECS_W-1:0] default_on_reg;
    logic [SECS_W-1:0] max_on_reg;
    logic [TPS_W-1:0]  tps_reg;
    logic              active_low_reg;

    logic              s1_valid_reg;
    logic              s1_action_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic     s1_has_result;
    logic     advance;
    verdict_t verdict;
    result_t  result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_on_reg <= DEFAULT_ON_SECONDS_RST;
            max_on_reg     <= MAX_ON_SECONDS_RST;
            tps_reg        <= TICKS_PER_SECOND_RST;
            active_low_reg <= ACTIVE_LOW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEFAULT_ON_SECONDS: default_on_reg <= cfg_data[SECS_W-1:0];
                REG_MAX_ON_SECONDS:     max_on_reg     <= cfg_data[SECS_W-1:0];
                REG_TICKS_PER_SECOND:   tps_reg        <= cfg_data[TPS_W-1:0];
                REG_ACTIVE_LOW:         active_low_reg <= cfg_data[0];
                default:                active_low_reg <= active_low_reg;
            endcase
        end
    end

    // staged item moves on unless it would overwrite a result not yet taken
    assign s1_has_result = s1_action_reg || s1_last_reg;
    assign advance       = s1_valid_reg && !(s1_has_result && m_valid_reg && !m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_action_reg <= s_axis_tuser[0];
            s1_char_reg   <= s_axis_tdata[CHAR_W-1:0];
            s1_last_reg   <= s_axis_tlast;
        end
    end

    rcao_parser #(
        .CMD_BUFFER_BYTES (CMD_BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance && !s1_action_reg),
        .char_byte (s1_char_reg),
        .last_char (s1_last_reg),
        .verdict   (verdict)
    );

    rcao_relay u_relay (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .is_tick          (s1_action_reg),
        .cmd_end          (s1_last_reg),
        .verdict          (verdict),
        .run_default_secs (default_on_reg),
        .run_cap_secs     (max_on_reg),
        .ticks_per_second (tps_reg),
        .active_low       (active_low_reg),
        .result           (result)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (advance && s1_has_result)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_has_result)
            m_data_reg <= {3'b000, result.state_changed, result.pin_level,
                           result.relay_on, result.status};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== hdl/rcao_parser.sv =====
module rcao_parser #(
    parameter int CMD_BUFFER_BYTES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [rcao_pkg::CHAR_W-1:0]  char_byte,
    input  logic                         last_char,
    output rcao_pkg::verdict_t           verdict
);
    import rcao_pkg::*;

    localparam int CNT_W = $clog2(CMD_BUFFER_BYTES + 1);
    localparam logic [CNT_W:0]   BODY_LIMIT = (CNT_W + 1)'(CMD_BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] PEND_SAT   = CNT_W'(CMD_BUFFER_BYTES);

    typedef struct packed {
        parse_state_t       state;
        logic [VALUE_W-1:0] value;
    } parse_t;

    logic [CNT_W-1:0] body_reg, body_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             seen_reg, seen_next;
    logic             too_long_reg, too_long_next;
    parse_t           parse_reg, parse_next;
    parse_t           after_space;
    logic             char_is_ws;
    logic [CNT_W:0]   fill_sum;

    // one body token through the recogniser of OFF, ON and ON:[ws][+]digits
    function automatic parse_t parse_token(parse_t cur, logic [CHAR_W-1:0] c);
        parse_t              nxt;
        logic [CHAR_W-1:0]   uc;
        logic                is_digit;
        logic [3:0]          digit;
        logic [11:0]         acc;
        nxt      = cur;
        uc       = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_GAP : c;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        digit    = 4'(c - CH_ZERO);
        acc      = (12'(cur.value) << 3) + (12'(cur.value) << 1) + 12'(digit);
        unique case (cur.state)
            P_START: nxt.state = (uc == CH_O) ? P_O : P_FAIL;
            P_O:
            begin
                if (uc == CH_N)
                    nxt.state = P_ON;
                else if (uc == CH_F)
                    nxt.state = P_OF;
                else
                    nxt.state = P_FAIL;
            end
            P_OF:    nxt.state = (uc == CH_F) ? P_OFF : P_FAIL;
            P_OFF:   nxt.state = P_FAIL;
            P_ON:    nxt.state = (c == CH_COLON) ? P_COLON : P_FAIL;
            P_COLON:
            begin
                if (c == CH_SPACE)
                    nxt.state = P_COLON;
                else if (c == CH_PLUS)
                    nxt.state = P_SIGN;
                else if (is_digit)
                begin
                    nxt.state = P_DIGITS;
                    nxt.value = VALUE_W'(digit);
                end
                else
                    nxt.state = P_FAIL;
            end
            P_SIGN:
            begin
                if (is_digit)
                begin
                    nxt.state = P_DIGITS;
                    nxt.value = VALUE_W'(digit);
                end
                else
                    nxt.state = P_FAIL;
            end
            P_DIGITS:
            begin
                if (is_digit)
                    nxt.value = (acc > 12'(VALUE_CAP)) ? VALUE_CAP : acc[VALUE_W-1:0];
                else
                    nxt.state = P_FAIL;
            end
            P_FAIL:  nxt.state = P_FAIL;
            default: nxt.state = P_FAIL;
        endcase
        return nxt;
    endfunction

    assign char_is_ws = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
    assign fill_sum   = {1'b0, body_reg} + {1'b0, pending_reg};

    always_comb
    begin
        body_next     = body_reg;
        pending_next  = pending_reg;
        seen_next     = seen_reg;
        too_long_next = too_long_reg;
        parse_next    = parse_reg;
        after_space   = (pending_reg != '0) ? parse_token(parse_reg, CH_SPACE) : parse_reg;
        if (char_is_ws)
        begin
            if (seen_reg && pending_reg < PEND_SAT)
                pending_next = pending_reg + 1'b1;
        end
        else
        begin
            seen_next = 1'b1;
            if (!too_long_reg)
            begin
                if (fill_sum >= BODY_LIMIT)
                    too_long_next = 1'b1;
                else
                begin
                    // internal whitespace run acts as a single space token
                    body_next    = fill_sum[CNT_W-1:0] + 1'b1;
                    pending_next = '0;
                    parse_next   = parse_token(after_space, char_byte);
                end
            end
        end
    end

    always_comb
    begin
        verdict.cmd_off        = (parse_next.state == P_OFF);
        verdict.cmd_on_default = (parse_next.state == P_ON);
        verdict.value          = parse_next.value;
        verdict.accepted       = !too_long_next &&
                                 (parse_next.state == P_OFF || parse_next.state == P_ON ||
                                  (parse_next.state == P_DIGITS && parse_next.value != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg     <= '0;
            pending_reg  <= '0;
            seen_reg     <= 1'b0;
            too_long_reg <= 1'b0;
            parse_reg    <= '{state: P_START, value: '0};
        end
        else if (step)
        begin
            if (last_char)
            begin
                body_reg     <= '0;
                pending_reg  <= '0;
                seen_reg     <= 1'b0;
                too_long_reg <= 1'b0;
                parse_reg    <= '{state: P_START, value: '0};
            end
            else
            begin
                body_reg     <= body_next;
                pending_reg  <= pending_next;
                seen_reg     <= seen_next;
                too_long_reg <= too_long_next;
                parse_reg    <= parse_next;
            end
        end
    end

endmodule

// ===== hdl/rcao_relay.sv =====
module rcao_relay (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         is_tick,
    input  logic                         cmd_end,
    input  rcao_pkg::verdict_t           verdict,
    input  logic [rcao_pkg::SECS_W-1:0]  run_default_secs,
    input  logic [rcao_pkg::SECS_W-1:0]  run_cap_secs,
    input  logic [rcao_pkg::TPS_W-1:0]   ticks_per_second,
    input  logic                         active_low,
    output rcao_pkg::result_t            result
);
    import rcao_pkg::*;

    logic              relay_reg, relay_next;
    logic              running_reg, running_next;
    logic [SECS_W-1:0] secs_reg, secs_next;
    logic [TPS_W-1:0]  prescale_reg, prescale_next;
    logic [TPS_W-1:0]  tps_eff;
    logic [TPS_W:0]    prescale_inc;
    logic [SECS_W-1:0] secs_dec;
    logic [SECS_W-1:0] clamped;
    logic [SECS_W-1:0] run_secs;
    logic              changed;
    logic [STATUS_W-1:0] status;

    assign tps_eff      = (ticks_per_second == '0) ? TPS_W'(1) : ticks_per_second;
    assign prescale_inc = {1'b0, prescale_reg} + 1'b1;
    assign secs_dec     = (secs_reg != '0) ? secs_reg - 1'b1 : secs_reg;
    assign clamped      = (verdict.value > {1'b0, run_cap_secs}) ?
                          run_cap_secs : verdict.value[SECS_W-1:0];
    assign run_secs     = verdict.cmd_on_default ? run_default_secs : clamped;

    always_comb
    begin
        relay_next    = relay_reg;
        running_next  = running_reg;
        secs_next     = secs_reg;
        prescale_next = prescale_reg;
        changed       = 1'b0;
        status        = STATUS_TICK;
        if (is_tick)
        begin
            if (running_reg)
            begin
                if (prescale_inc >= {1'b0, tps_eff})
                begin
                    prescale_next = '0;
                    secs_next     = secs_dec;
                    if (secs_dec == '0)
                    begin
                        running_next = 1'b0;
                        relay_next   = 1'b0;
                        changed      = relay_reg;
                    end
                end
                else
                    prescale_next = prescale_inc[TPS_W-1:0];
            end
        end
        else if (verdict.accepted)
        begin
            status = STATUS_ACCEPTED;
            if (verdict.cmd_off)
            begin
                running_next = 1'b0;
                relay_next   = 1'b0;
                changed      = relay_reg;
            end
            else
            begin
                relay_next   = 1'b1;
                changed      = !relay_reg;
                running_next = (run_secs != '0);
                if (run_secs != '0)
                begin
                    secs_next     = run_secs;
                    prescale_next = '0;
                end
            end
        end
        else
            status = STATUS_REJECTED;
    end

    always_comb
    begin
        result.status        = status;
        result.relay_on      = relay_next;
        result.pin_level     = relay_next ^ active_low;
        result.state_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg    <= 1'b0;
            running_reg  <= 1'b0;
            secs_reg     <= '0;
            prescale_reg <= '0;
        end
        else if (step && (is_tick || cmd_end))
        begin
            relay_reg    <= relay_next;
            running_reg  <= running_next;
            secs_reg     <= secs_next;
            prescale_reg <= prescale_next;
        end
    end

endmodule

// ===== hdl/rcao_checker.sv =====
module rcao_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rcao_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rcao_pkg::*;

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result during reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // a rejected command leaves the relay alone
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == STATUS_REJECTED |-> !m_axis_tdata[4])
        else $error("rejected command changed relay state");

    // ticks can only switch the relay off
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == STATUS_TICK && m_axis_tdata[4]
        |-> !m_axis_tdata[2])
        else $error("tick switched relay on");

endmodule

bind relay_command_with_auto_off_top rcao_checker u_rcao_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/relay_result_check.sv =====
`timescale 1ns / 100ps

// watches both streams and the register port, predicts each result and compares
module relay_result_check #(
    parameter int CMD_BUFFER_BYTES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [rcao_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic [0:0]                       s_axis_tuser,   // [0] action
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] cmd_status, [2] relay_on, [3] pin_level, [4] state_changed, [7:5] zero
    input  logic [rcao_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_wr_en,
    input  logic [rcao_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcao_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_count,
    output int                               waiting_results
);
    import rcao_pkg::*;

    localparam int CMD_LIMIT      = CMD_BUFFER_BYTES - 1;
    localparam int NUMBER_CEILING = 65535;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // command line as trimmed so far
    logic [CHAR_W-1:0] line_buf [CMD_BUFFER_BYTES];
    int  text_len;
    int  held_spaces;
    bit  got_text;
    bit  overflowed;

    // relay and countdown
    bit  relay_now_on;
    bit  countdown_active;
    int  secs_remaining;
    int  tick_count;
    bit  flipped;

    // register copies
    logic [SECS_W-1:0] dflt_secs;
    logic [SECS_W-1:0] cap_secs;
    logic [TPS_W-1:0]  tps_reg;
    logic              low_active;

    result_t expected_q[$];
    result_t due;

    function automatic bit is_space(logic [CHAR_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(logic [CHAR_W-1:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_GAP : c;
    endfunction

    function automatic void set_relay(bit on);
        flipped      = (on != relay_now_on);
        relay_now_on = on;
    endfunction

    function automatic void start_run(int secs);
        countdown_active = 1'b0;
        set_relay(1'b1);
        if (secs > 0)
        begin
            countdown_active = 1'b1;
            secs_remaining   = secs;
            tick_count       = 0;
        end
    endfunction

    function automatic void halt_relay();
        countdown_active = 1'b0;
        set_relay(1'b0);
    endfunction

    function automatic void clear_line();
        text_len    = 0;
        held_spaces = 0;
        got_text    = 1'b0;
        overflowed  = 1'b0;
    endfunction

    function automatic void feed_char(logic [CHAR_W-1:0] c);
        if (is_space(c))
        begin
            if (got_text && held_spaces < CMD_BUFFER_BYTES)
                held_spaces++;
            return;
        end
        got_text = 1'b1;
        if (overflowed)
            return;
        if (text_len + held_spaces >= CMD_LIMIT)
        begin
            overflowed = 1'b1;
            return;
        end
        // whitespace inside the command is kept as plain spaces
        while (held_spaces > 0)
        begin
            line_buf[text_len] = CH_SPACE;
            text_len++;
            held_spaces--;
        end
        line_buf[text_len] = c;
        text_len++;
    endfunction

    function automatic logic [STATUS_W-1:0] run_command();
        int i;
        int val;
        bit neg;
        bit digits;
        i      = 3;
        val    = 0;
        neg    = 1'b0;
        digits = 1'b0;
        flipped = 1'b0;
        if (overflowed || text_len == 0 || text_len > CMD_LIMIT)
            return STATUS_REJECTED;
        if (text_len == 3 && fold(line_buf[0]) == CH_O && fold(line_buf[1]) == CH_F
            && fold(line_buf[2]) == CH_F)
        begin
            halt_relay();
            return STATUS_ACCEPTED;
        end
        if (text_len == 2 && fold(line_buf[0]) == CH_O && fold(line_buf[1]) == CH_N)
        begin
            start_run(int'(dflt_secs));
            return STATUS_ACCEPTED;
        end
        if (text_len >= 3 && fold(line_buf[0]) == CH_O && fold(line_buf[1]) == CH_N
            && line_buf[2] == CH_COLON)
        begin
            while (i < text_len && is_space(line_buf[i]))
                i++;
            if (i < text_len && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS))
            begin
                neg = (line_buf[i] == CH_MINUS);
                i++;
            end
            while (i < text_len && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE)
            begin
                digits = 1'b1;
                val = val * 10 + int'(line_buf[i] - CH_ZERO);
                if (val > NUMBER_CEILING)
                    val = NUMBER_CEILING;
                i++;
            end
            if (!digits || i != text_len || neg || val == 0)
                return STATUS_REJECTED;
            if (val > int'(cap_secs))
                val = int'(cap_secs);
            start_run(val);
            return STATUS_ACCEPTED;
        end
        return STATUS_REJECTED;
    endfunction

    function automatic void count_tick();
        int tps;
        flipped = 1'b0;
        if (countdown_active)
        begin
            tps = (tps_reg == '0) ? 1 : int'(tps_reg);
            tick_count++;
            if (tick_count >= tps)
            begin
                tick_count = 0;
                if (secs_remaining > 0)
                    secs_remaining--;
                if (secs_remaining == 0)
                begin
                    countdown_active = 1'b0;
                    set_relay(1'b0);
                end
            end
        end
    endfunction

    function automatic void push_result(logic [STATUS_W-1:0] status);
        result_t r;
        r.status        = status;
        r.relay_on      = relay_now_on;
        r.pin_level     = relay_now_on ^ low_active;
        r.state_changed = flipped;
        expected_q.push_back(r);
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            foreach (line_buf[k])
                line_buf[k] = '0;
            relay_now_on     = 1'b0;
            countdown_active = 1'b0;
            secs_remaining   = 0;
            tick_count       = 0;
            flipped          = 1'b0;
            dflt_secs        = DEFAULT_ON_SECONDS_RST;
            cap_secs         = MAX_ON_SECONDS_RST;
            tps_reg          = TICKS_PER_SECOND_RST;
            low_active       = ACTIVE_LOW_RST;
            expected_q.delete();
            mismatch_count   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DEFAULT_ON_SECONDS: dflt_secs  = cfg_data[SECS_W-1:0];
                    REG_MAX_ON_SECONDS:     cap_secs   = cfg_data[SECS_W-1:0];
                    REG_TICKS_PER_SECOND:   tps_reg    = cfg_data[TPS_W-1:0];
                    REG_ACTIVE_LOW:         low_active = cfg_data[0];
                    default: ;
                endcase
            end

            // results first, so a stray result never meets an expectation from this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: tdata 0x%02h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    due = expected_q.pop_front();
                    check_field("cmd_status", due.status, m_axis_tdata[1:0]);
                    check_field("relay_on", due.relay_on, m_axis_tdata[2]);
                    check_field("pin_level", due.pin_level, m_axis_tdata[3]);
                    check_field("state_changed", due.state_changed, m_axis_tdata[4]);
                    check_field("tdata padding", 0, m_axis_tdata[7:5]);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                begin
                    count_tick();
                    push_result(STATUS_TICK);
                end
                else
                begin
                    feed_char(s_axis_tdata[CHAR_W-1:0]);
                    if (s_axis_tlast)
                    begin
                        push_result(run_command());
                        clear_line();
                    end
                end
            end
        end
        waiting_results = expected_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rcao_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASE_COUNT  = 8;
    localparam int SETTLE_TICKS = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] char_byte
    logic [0:0]             s_axis_tuser = '0;   // [0] action
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] cmd_status, [2] relay_on, [3] pin_level, [4] state_changed, [7:5] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int waiting_results;
    int send_gap_pct = 0;
    int take_gap_pct = 0;
    int hold_left = 0;
    int hold_asks = 0;
    int hold_taken = 0;
    bit held_off = 1'b0;
    int cycle_count = 0;
    int phase_items = 0;

    logic [CHAR_W-1:0] cmd_text[$];

    relay_command_with_auto_off_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    relay_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .waiting_results (waiting_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_taken != hold_asks)
        begin
            hold_taken    <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch, input logic fin);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        phase_items++;
    endtask

    // data and tlast carry noise on ticks
    task automatic send_tick();
        send_item(1'b1, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic send_command();
        int n;
        n = cmd_text.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                send_tick();
            send_item(1'b0, cmd_text[i], i == n - 1);
        end
        cmd_text.delete();
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting_results != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic program_regs(input logic [SECS_W-1:0] dflt, input logic [SECS_W-1:0] cap,
                                input logic [TPS_W-1:0] tps, input logic low);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEFAULT_ON_SECONDS;
        cfg_data  <= CFG_DATA_W'(dflt);
        @(posedge clk);
        cfg_index <= REG_MAX_ON_SECONDS;
        cfg_data  <= CFG_DATA_W'(cap);
        @(posedge clk);
        cfg_index <= REG_TICKS_PER_SECOND;
        cfg_data  <= CFG_DATA_W'(tps);
        @(posedge clk);
        cfg_index <= REG_ACTIVE_LOW;
        cfg_data  <= CFG_DATA_W'(low);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] rand_ws();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
    endfunction

    function automatic void add_ws(int n);
        repeat (n) cmd_text.push_back(rand_ws());
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            cmd_text.push_back(s[i]);
    endfunction

    // letters in random case
    function automatic void add_word(string s);
        logic [CHAR_W-1:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= CH_O - 8'd14 && c <= CH_O + 8'd11 && $urandom_range(1))
                c = c + CASE_GAP;
            cmd_text.push_back(c);
        end
    endfunction

    function automatic void add_number();
        int n;
        int r;
        r = $urandom_range(9);
        if (r == 0)
            cmd_text.push_back(CH_PLUS);
        else if (r == 1)
            cmd_text.push_back(CH_MINUS);
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        repeat (n)
            cmd_text.push_back(($urandom_range(9) == 0) ? CH_ZERO
                                                         : CH_ZERO + CHAR_W'($urandom_range(9)));
    endfunction

    task automatic random_command();
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            add_ws($urandom_range(2));
            add_word("OFF");
            add_ws($urandom_range(3));
        end
        else if (pick < 30)
        begin
            add_ws($urandom_range(2));
            add_word("ON");
            add_ws($urandom_range(3));
        end
        else if (pick < 75)
        begin
            add_ws($urandom_range(1));
            add_word("ON");
            cmd_text.push_back(CH_COLON);
            if ($urandom_range(9) < 3)
                add_ws($urandom_range(1, 2));
            add_number();
            add_ws($urandom_range(2));
            // broken variant: one character swapped for any byte
            if (pick >= 65)
                cmd_text[$urandom_range(cmd_text.size() - 1)] = CHAR_W'($urandom_range(255));
        end
        else if (pick < 80)
        begin
            // zero-padded value around the length limit
            add_word("ON");
            cmd_text.push_back(CH_COLON);
            repeat ($urandom_range(11, 14)) cmd_text.push_back(CH_ZERO);
            cmd_text.push_back(CH_ZERO + CHAR_W'($urandom_range(1, 9)));
        end
        else if (pick < 85)
            add_ws($urandom_range(1, 20));
        else if (pick < 89)
            repeat ($urandom_range(1, 6)) cmd_text.push_back(CHAR_W'($urandom_range(255)));
        else if (pick < 94)
        begin
            k = $urandom_range(3);
            if (k == 0)
            begin
                add_word("OFF");
                add_ws($urandom_range(17, 20));
            end
            else if (k == 1)
            begin
                add_word("OF");
                add_ws($urandom_range(10, 18));
                add_word("F");
            end
            else if (k == 2)
            begin
                add_word("ON");
                cmd_text.push_back(CH_COLON);
                add_ws($urandom_range(1, 3));
                add_number();
            end
            else
            begin
                add_word("O");
                add_ws(1);
                add_word("N");
            end
        end
        else
        begin
            repeat ($urandom_range(1, 40)) send_tick();
        end
        send_command();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 3)
            begin
                send_gap_pct = 27;
                take_gap_pct = 75;
            end
            else if (phase < 6)
            begin
                send_gap_pct = 75;
                take_gap_pct = 27;
            end
            else
            begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end

            case (phase)
                0: ;
                1: program_regs(8'd0, 8'd255, 20'd1, 1'b0);
                2: program_regs(8'd255, 8'd1, 20'd2, 1'b1);
                3: program_regs(8'd3, 8'd0, 20'd0, 1'b0);
                4: program_regs(8'd1, 8'd12, 20'd1000000, 1'b1);
                default: program_regs(SECS_W'($urandom_range(8)), SECS_W'($urandom_range(1, 20)),
                                      TPS_W'($urandom_range(1, 4)), 1'($urandom_range(1)));
            endcase
            phase_items = 0;

            if (phase == 0)
            begin
                add_text("on");
                send_command();
                send_tick();
                add_text(" oFf");
                cmd_text.push_back(CH_TAB);
                send_command();
                add_text("ON:-3");
                send_command();
                add_text("on:99999");
                send_command();
                cmd_text.push_back(CH_CR);
                send_command();
                cmd_text.push_back(8'hFF);
                send_command();
            end

            while (phase_items < PHASE_ITEMS)
            begin
                random_command();
                if (phase == 1 && !held_off && phase_items >= PHASE_ITEMS / 2)
                begin
                    hold_asks++;
                    held_off = 1'b1;
                end
                if (phase == 4 && phase_items >= PHASE_ITEMS / 2
                    && phase_items < PHASE_ITEMS / 2 + 30)
                    drain();
            end
            drain();
        end

        if (mismatch_count == 0 && waiting_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
